[hw/rtl/dtm_pkg.sv]
// Shared types and constants for the divider and reload timer.
package dtm_pkg;

   localparam int ACC_W      = 16;   // shared unit and divider accumulator width
   localparam int TIM_ACC_W  = 11;   // timer accumulator: below longest period plus one item
   localparam int PER_W      = 11;   // prescaler period width
   localparam int IRQ_W      = 3;

   localparam logic [7:0] COUNT_MAX = 8'hFF;
   localparam logic [IRQ_W-1:0] IRQ_MAX = '1;

   // input item kinds
   localparam logic [1:0] KIND_TICK      = 2'd0;
   localparam logic [1:0] KIND_WRITE_CNT = 2'd1;
   localparam logic [1:0] KIND_RESET_DIV = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_RELOAD    = 2'd0;
   localparam logic [1:0] CSR_ENABLE    = 2'd1;
   localparam logic [1:0] CSR_PRESCALE  = 2'd2;

   // shared unit operations
   localparam logic ALU_ADD_SAT = 1'b0;
   localparam logic ALU_SUB     = 1'b1;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] tick_count;
      logic [7:0] new_value;
   } req_type;

   typedef struct packed {
      logic [7:0]       divider_value;
      logic [7:0]       counter_value;
      logic [IRQ_W-1:0] interrupt_count;
   } rsp_type;

   typedef struct packed {
      logic             op;
      logic [ACC_W-1:0] a;
      logic [ACC_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ACC_W-1:0] result;
      logic             ge;
   } alu_rsp_type;

endpackage

[hw/rtl/divider_and_reload_timer_core.sv]
// Top level of the divider and reload timer: sequencer, state and output register.
//
// Usage notes
// - req channel (valid/stall) carries one item: a tick count, a counter write
//   or a divider reset. A transfer is taken only while the sequencer is idle.
// - rsp channel (valid/stall) returns exactly one result per item: divider,
//   counter and the number of overflow interrupts the item raised.
// - csr port: plain write (csr_we, csr_index, csr_wdata); index 0 reload value,
//   1 counter enable, 2 prescaler select (also clears the timer accumulator).
//   Other indexes are ignored. Write only while the block is idle.
// - Steps per item: a non-tick item goes straight to the finish state. A tick item
//   runs divider add and divider compare, then, with the counter enabled, timer add,
//   then one compare-subtract for each of the N prescaler steps, where
//   N = (timer accumulator + ticks * CYCLES_PER_TICK) / period, and a final
//   compare. The steps run in turn on the one shared add/compare unit.
// - The result sits in an output register; the next item is taken while it
//   waits. If a result is still stalled when the next one is ready, the
//   sequencer holds in its finish state until the register frees.
// - Reset (synchronous, active high) clears all registers and counters but the cycle count and result data.
module divider_and_reload_timer_core
   import dtm_pkg::*;
#(
   parameter int CYCLES_PER_TICK   = 4,
   parameter int DIVIDER_PERIOD    = 256,
   parameter int PRESCALE_PERIOD_0 = 1024,
   parameter int PRESCALE_PERIOD_1 = 16,
   parameter int PRESCALE_PERIOD_2 = 64,
   parameter int PRESCALE_PERIOD_3 = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   // cycles per item: up to 15 ticks
   localparam int CYC_W = $clog2(15 * CYCLES_PER_TICK + 1);

   localparam logic [PER_W-1:0] PERIODS [4] = '{
      PER_W'(PRESCALE_PERIOD_0), PER_W'(PRESCALE_PERIOD_1),
      PER_W'(PRESCALE_PERIOD_2), PER_W'(PRESCALE_PERIOD_3)
   };

   // sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DIV_ADD  = 3'd1;
   localparam logic [2:0] ST_DIV_SUB  = 3'd2;
   localparam logic [2:0] ST_TIM_ADD  = 3'd3;
   localparam logic [2:0] ST_TIM_LOOP = 3'd4;
   localparam logic [2:0] ST_FINISH   = 3'd5;

   logic [2:0]           state_ff,     state_in;
   logic [7:0]           reload_ff,    reload_in;
   logic                 enable_ff,    enable_in;
   logic [1:0]           prescale_ff,  prescale_in;
   logic [7:0]           divider_ff,   divider_in;
   logic [ACC_W-1:0]     div_acc_ff,   div_acc_in;
   logic [7:0]           timer_ff,     timer_in;
   logic [TIM_ACC_W-1:0] tim_acc_ff,   tim_acc_in;
   logic [IRQ_W-1:0]     irq_ff,       irq_in;
   logic [CYC_W-1:0]     cycles_ff,    cycles_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff,  rsp_data_in;

   logic [PER_W-1:0] period;
   alu_req_type      alu_req;
   alu_rsp_type      alu_rsp;

   assign period    = PERIODS[prescale_ff];
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   dtm_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // operand steering for the shared unit
   always_comb begin
      alu_req.op = ALU_SUB;
      alu_req.a  = ACC_W'(tim_acc_ff);
      alu_req.b  = ACC_W'(period);
      unique case (state_ff)
         ST_DIV_ADD: begin
            alu_req.op = ALU_ADD_SAT;
            alu_req.a  = div_acc_ff;
            alu_req.b  = ACC_W'(cycles_ff);
         end
         ST_DIV_SUB: begin
            alu_req.a  = div_acc_ff;
            alu_req.b  = ACC_W'(DIVIDER_PERIOD);
         end
         ST_TIM_ADD: begin
            alu_req.op = ALU_ADD_SAT;
            alu_req.b  = ACC_W'(cycles_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      reload_in    = reload_ff;
      enable_in    = enable_ff;
      prescale_in  = prescale_ff;
      divider_in   = divider_ff;
      div_acc_in   = div_acc_ff;
      timer_in     = timer_ff;
      tim_acc_in   = tim_acc_ff;
      irq_in       = irq_ff;
      cycles_in    = cycles_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               irq_in    = '0;
               cycles_in = CYC_W'(req_data.tick_count * CYCLES_PER_TICK);
               state_in  = ST_FINISH;
               unique case (req_data.kind)
                  KIND_TICK:      state_in = ST_DIV_ADD;
                  KIND_WRITE_CNT: timer_in = req_data.new_value;
                  KIND_RESET_DIV: begin
                     divider_in = '0;
                     tim_acc_in = '0;   // divider reset also clears timer accumulator
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV_ADD: begin
            div_acc_in = alu_rsp.result;   // saturates at all ones
            state_in   = ST_DIV_SUB;
         end
         ST_DIV_SUB: begin
            if (alu_rsp.ge) begin
               div_acc_in = alu_rsp.result;
               divider_in = divider_ff + 8'd1;
            end
            state_in = enable_ff ? ST_TIM_ADD : ST_FINISH;
         end
         ST_TIM_ADD: begin
            tim_acc_in = alu_rsp.result[TIM_ACC_W-1:0];
            state_in   = ST_TIM_LOOP;
         end
         ST_TIM_LOOP: begin
            // one prescaler period per cycle
            if (alu_rsp.ge) begin
               tim_acc_in = alu_rsp.result[TIM_ACC_W-1:0];
               if (timer_ff == COUNT_MAX) begin
                  timer_in = reload_ff;
                  if (irq_ff != IRQ_MAX) begin
                     irq_in = irq_ff + IRQ_W'(1);
                  end
               end else begin
                  timer_in = timer_ff + 8'd1;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.divider_value   = divider_ff;
               rsp_data_in.counter_value   = timer_ff;
               rsp_data_in.interrupt_count = irq_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_RELOAD:   reload_in = csr_wdata;
            CSR_ENABLE:   enable_in = csr_wdata[0];
            CSR_PRESCALE: begin
               prescale_in = csr_wdata[1:0];
               tim_acc_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         reload_ff    <= '0;
         enable_ff    <= 1'b0;
         prescale_ff  <= '0;
         divider_ff   <= '0;
         div_acc_ff   <= '0;
         timer_ff     <= '0;
         tim_acc_ff   <= '0;
         irq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reload_ff    <= reload_in;
         enable_ff    <= enable_in;
         prescale_ff  <= prescale_in;
         divider_ff   <= divider_in;
         div_acc_ff   <= div_acc_in;
         timer_ff     <= timer_in;
         tim_acc_ff   <= tim_acc_in;
         irq_ff       <= irq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cycles_ff   <= cycles_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   // timer accumulator is always below the selected period between items
   a_tim_acc_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (PER_W'(tim_acc_ff) < period))
      else $error("timer accumulator not below prescaler period when idle");

   // a non-tick item goes straight to the finish state
   a_non_tick_short: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.kind != KIND_TICK)) |=>
      (state_ff == ST_FINISH))
      else $error("non-tick item did not go straight to finish");

   // a new result only ever comes from the finish state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result raised outside finish state");
`endif

endmodule

[hw/rtl/dtm_alu.sv]
// Shared saturating add / subtract-and-compare unit.
module dtm_alu
   import dtm_pkg::*;
(
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   logic [ACC_W:0] sum;
   logic [ACC_W:0] diff;

   always_comb begin
      sum  = {1'b0, alu_req.a} + {1'b0, alu_req.b};
      diff = {1'b0, alu_req.a} - {1'b0, alu_req.b};
      case (alu_req.op)
         ALU_ADD_SAT: alu_rsp.result = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
         ALU_SUB:     alu_rsp.result = diff[ACC_W-1:0];
         default:     alu_rsp.result = diff[ACC_W-1:0];
      endcase
      alu_rsp.ge = !diff[ACC_W];   // no borrow: a >= b
   end

endmodule
